/* rtl/core/keypad_setpoint_menu_macros.svh */
// ---------------------------------------------------------------------------
// keypad_setpoint_menu_macros.svh
// Assertion macros used by the checker file kpsm_checker.
// ---------------------------------------------------------------------------
`ifndef KEYPAD_SETPOINT_MENU_MACROS_SVH
`define KEYPAD_SETPOINT_MENU_MACROS_SVH

// same-cycle implication
`define KPSM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kpsm assertion failed");

// next-cycle implication
`define KPSM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kpsm assertion failed");

`endif

/* rtl/core/kpsm_pkg.sv */
// ---------------------------------------------------------------------------
// kpsm_pkg
// Types and constants of the keypad setpoint menu.
// ---------------------------------------------------------------------------
package kpsm_pkg;

    localparam int MAX_DIGITS_DEF = 3;

    localparam int PCT_W   = 7;
    localparam int ROW_W   = 3;
    localparam int COL_W   = 2;
    localparam int KEY_W   = ROW_W + COL_W;
    localparam int ENTRY_W = 10;
    localparam int LEN_W   = 2;
    localparam int DIGIT_W = 4;

    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(4);
    localparam logic [KEY_W-1:0] NO_KEY   = KEY_W'(31);

    // key codes: row*4 + col
    localparam logic [KEY_W-1:0] CODE_F1    = KEY_W'(0);
    localparam logic [KEY_W-1:0] CODE_F2    = KEY_W'(1);
    localparam logic [KEY_W-1:0] CODE_D1    = KEY_W'(4);
    localparam logic [KEY_W-1:0] CODE_D2    = KEY_W'(5);
    localparam logic [KEY_W-1:0] CODE_D3    = KEY_W'(6);
    localparam logic [KEY_W-1:0] CODE_D4    = KEY_W'(8);
    localparam logic [KEY_W-1:0] CODE_D5    = KEY_W'(9);
    localparam logic [KEY_W-1:0] CODE_D6    = KEY_W'(10);
    localparam logic [KEY_W-1:0] CODE_D7    = KEY_W'(12);
    localparam logic [KEY_W-1:0] CODE_D8    = KEY_W'(13);
    localparam logic [KEY_W-1:0] CODE_D9    = KEY_W'(14);
    localparam logic [KEY_W-1:0] CODE_ESC   = KEY_W'(15);
    localparam logic [KEY_W-1:0] CODE_BKSP  = KEY_W'(16);
    localparam logic [KEY_W-1:0] CODE_D0    = KEY_W'(17);
    localparam logic [KEY_W-1:0] CODE_ENTER = KEY_W'(19);

    localparam int TOP_PERCENT = 100;

    // floor(v/10) == (v*6554) >> 16 for v < 16384
    localparam int DIV10_RECIP = 6554;
    localparam int DIV10_SHIFT = 16;

    typedef enum logic [1:0] {
        MODE_MENU = 2'd0,
        MODE_EDIT = 2'd1,
        MODE_INFO = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        KEY_BLANK,
        KEY_F1,
        KEY_F2,
        KEY_DIGIT,
        KEY_BKSP,
        KEY_ENTER,
        KEY_ESC
    } key_kind_t;

    typedef struct packed {
        logic               present;
        logic [KEY_W-1:0]   code;
        key_kind_t          kind;
        logic [DIGIT_W-1:0] digit;
    } key_info_t;

endpackage

/* rtl/core/kpsm_key_decode.sv */
// ---------------------------------------------------------------------------
// kpsm_key_decode
// Maps a scanned row/column to a key code, key kind and digit value.
// ---------------------------------------------------------------------------
module kpsm_key_decode
    import kpsm_pkg::*;
(
    input  logic             key_pressed,
    input  logic [ROW_W-1:0] key_row,
    input  logic [COL_W-1:0] key_col,
    output key_info_t        key
);

    logic [KEY_W-1:0] code;

    assign code = {key_row, key_col};

    always_comb
    begin
        key.present = key_pressed && (key_row <= LAST_ROW);
        key.code    = code;
        key.kind    = KEY_BLANK;
        key.digit   = '0;
        unique case (code)
            CODE_F1:    key.kind = KEY_F1;
            CODE_F2:    key.kind = KEY_F2;
            CODE_ESC:   key.kind = KEY_ESC;
            CODE_BKSP:  key.kind = KEY_BKSP;
            CODE_ENTER: key.kind = KEY_ENTER;
            CODE_D0:    begin key.kind = KEY_DIGIT; key.digit = DIGIT_W'(0); end
            CODE_D1:    begin key.kind = KEY_DIGIT; key.digit = DIGIT_W'(1); end
            CODE_D2:    begin key.kind = KEY_DIGIT; key.digit = DIGIT_W'(2); end
            CODE_D3:    begin key.kind = KEY_DIGIT; key.digit = DIGIT_W'(3); end
            CODE_D4:    begin key.kind = KEY_DIGIT; key.digit = DIGIT_W'(4); end
            CODE_D5:    begin key.kind = KEY_DIGIT; key.digit = DIGIT_W'(5); end
            CODE_D6:    begin key.kind = KEY_DIGIT; key.digit = DIGIT_W'(6); end
            CODE_D7:    begin key.kind = KEY_DIGIT; key.digit = DIGIT_W'(7); end
            CODE_D8:    begin key.kind = KEY_DIGIT; key.digit = DIGIT_W'(8); end
            CODE_D9:    begin key.kind = KEY_DIGIT; key.digit = DIGIT_W'(9); end
            default:    key.kind = KEY_BLANK;
        endcase
    end

endmodule

/* rtl/core/kpsm_menu_fsm.sv */
// ---------------------------------------------------------------------------
// kpsm_menu_fsm
// Screen state, entry buffer, held-key tracking and the result register.
// ---------------------------------------------------------------------------
module kpsm_menu_fsm
    import kpsm_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  key_info_t          key,
    input  logic [PCT_W-1:0]   current_percent,
    output logic [1:0]         screen_mode,
    output logic [ENTRY_W-1:0] entry_value,
    output logic [LEN_W-1:0]   entry_length,
    output logic               set_strobe,
    output logic [PCT_W-1:0]   set_percent
);

    localparam int MAX_LEN = (MAX_DIGITS > 3) ? MAX_DIGITS : 3;
    localparam int CNT_W   = $clog2(MAX_LEN + 1);
    localparam int DIG_VW  = $clog2(10 ** MAX_DIGITS);
    localparam int VAL_W   = (DIG_VW > PCT_W) ? DIG_VW : PCT_W;
    localparam int PROD_W  = VAL_W + 13;

    mode_t              mode_reg, mode_next;
    logic [VAL_W-1:0]   value_reg, value_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               fresh_reg, fresh_next;
    logic [KEY_W-1:0]   held_reg, held_next;

    logic [1:0]         screen_mode_reg;
    logic [ENTRY_W-1:0] entry_value_reg;
    logic [LEN_W-1:0]   entry_length_reg;
    logic               set_strobe_reg, set_strobe_next;
    logic [PCT_W-1:0]   set_percent_reg, set_percent_next;

    logic [1:0]         load_count;
    logic [VAL_W-1:0]   base_value;
    logic [CNT_W-1:0]   base_count;
    logic [VAL_W-1:0]   append_value;
    logic [PROD_W-1:0]  div_prod;
    logic [VAL_W-1:0]   value_div10;

    always_comb
    begin
        if (current_percent >= PCT_W'(100))
            load_count = 2'd3;
        else if (current_percent >= PCT_W'(10))
            load_count = 2'd2;
        else
            load_count = 2'd1;
    end

    assign base_value   = fresh_reg ? '0 : value_reg;
    assign base_count   = fresh_reg ? '0 : count_reg;
    assign append_value = (base_value << 3) + (base_value << 1) + VAL_W'(key.digit);
    assign div_prod     = PROD_W'(value_reg) * PROD_W'(DIV10_RECIP);
    assign value_div10  = VAL_W'(div_prod >> DIV10_SHIFT);

    always_comb
    begin
        mode_next        = mode_reg;
        value_next       = value_reg;
        count_next       = count_reg;
        fresh_next       = fresh_reg;
        held_next        = held_reg;
        set_strobe_next  = 1'b0;
        set_percent_next = '0;
        if (!key.present)
        begin
            held_next = NO_KEY;
        end
        else if (key.code != held_reg)
        begin
            held_next = key.code;
            unique case (mode_reg)
                MODE_MENU:
                begin
                    if (key.kind == KEY_F1)
                    begin
                        mode_next  = MODE_EDIT;
                        value_next = VAL_W'(current_percent);
                        count_next = CNT_W'(load_count);
                        fresh_next = 1'b1;
                    end
                    else if (key.kind == KEY_F2)
                    begin
                        mode_next = MODE_INFO;
                    end
                end
                MODE_EDIT:
                begin
                    unique case (key.kind)
                        KEY_DIGIT:
                        begin
                            fresh_next = 1'b0;
                            if (base_count < CNT_W'(MAX_DIGITS))
                            begin
                                value_next = append_value;
                                count_next = base_count + CNT_W'(1);
                            end
                            else
                            begin
                                value_next = base_value;
                                count_next = base_count;
                            end
                        end
                        KEY_BKSP:
                        begin
                            if (count_reg != '0)
                            begin
                                count_next = count_reg - CNT_W'(1);
                                value_next = value_div10;
                            end
                        end
                        KEY_ENTER:
                        begin
                            if (value_reg <= VAL_W'(TOP_PERCENT))
                            begin
                                set_strobe_next  = 1'b1;
                                set_percent_next = PCT_W'(value_reg);
                                mode_next        = MODE_MENU;
                            end
                        end
                        KEY_ESC:
                        begin
                            mode_next = MODE_MENU;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                MODE_INFO:
                begin
                    if (key.kind == KEY_ESC)
                        mode_next = MODE_MENU;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_MENU;
            value_reg <= '0;
            count_reg <= '0;
            fresh_reg <= 1'b1;
            held_reg  <= NO_KEY;
        end
        else if (step)
        begin
            mode_reg  <= mode_next;
            value_reg <= value_next;
            count_reg <= count_next;
            fresh_reg <= fresh_next;
            held_reg  <= held_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            screen_mode_reg  <= mode_next;
            entry_value_reg  <= ENTRY_W'(value_next);
            entry_length_reg <= LEN_W'(count_next);
            set_strobe_reg   <= set_strobe_next;
            set_percent_reg  <= set_percent_next;
        end
    end

    assign screen_mode  = screen_mode_reg;
    assign entry_value  = entry_value_reg;
    assign entry_length = entry_length_reg;
    assign set_strobe   = set_strobe_reg;
    assign set_percent  = set_percent_reg;

endmodule

/* rtl/core/keypad_setpoint_menu.sv */
// ---------------------------------------------------------------------------
// keypad_setpoint_menu
// Keypad-driven setpoint menu for a dimmer.
// ---------------------------------------------------------------------------
// Takes one scan beat per cycle while the scan side is not stalled and
// returns exactly one result beat for it: the beat passes the input register,
// then the screen/entry update into the result
// register. The menu state is updated as a beat moves from the input register
// into the result register, so a new beat can follow in every cycle; the
// scan side stalls only while a finished result is held by a result stall
// and the input register is occupied.
// ---------------------------------------------------------------------------
module keypad_setpoint_menu
    import kpsm_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               scan_valid,
    output logic               scan_stall,
    input  logic               key_pressed,
    input  logic [ROW_W-1:0]   key_row,
    input  logic [COL_W-1:0]   key_col,
    input  logic [PCT_W-1:0]   current_percent,

    output logic               result_valid,
    input  logic               result_stall,
    output logic [1:0]         screen_mode,
    output logic [ENTRY_W-1:0] entry_value,
    output logic [LEN_W-1:0]   entry_length,
    output logic               set_strobe,
    output logic [PCT_W-1:0]   set_percent
);

    logic             scan_valid_reg;
    logic             key_pressed_reg;
    logic [ROW_W-1:0] key_row_reg;
    logic [COL_W-1:0] key_col_reg;
    logic [PCT_W-1:0] percent_reg;
    logic             result_valid_reg;

    logic             advance;
    logic             step;
    key_info_t        key;

    assign advance    = !result_valid_reg || !result_stall;
    assign step       = scan_valid_reg && advance;
    assign scan_stall = scan_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (!scan_stall)
                scan_valid_reg <= scan_valid;
            if (advance)
                result_valid_reg <= scan_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan_valid && !scan_stall)
        begin
            key_pressed_reg <= key_pressed;
            key_row_reg     <= key_row;
            key_col_reg     <= key_col;
            percent_reg     <= current_percent;
        end
    end

    kpsm_key_decode u_decode (
        .key_pressed (key_pressed_reg),
        .key_row     (key_row_reg),
        .key_col     (key_col_reg),
        .key         (key)
    );

    kpsm_menu_fsm #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_fsm (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (step),
        .key             (key),
        .current_percent (percent_reg),
        .screen_mode     (screen_mode),
        .entry_value     (entry_value),
        .entry_length    (entry_length),
        .set_strobe      (set_strobe),
        .set_percent     (set_percent)
    );

    assign result_valid = result_valid_reg;

endmodule

/* rtl/core/kpsm_checker.sv */
// ---------------------------------------------------------------------------
// kpsm_checker
// Port-level checks of the keypad setpoint menu, bound to the top level.
// ---------------------------------------------------------------------------
`include "keypad_setpoint_menu_macros.svh"

module kpsm_checker
    import kpsm_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               scan_valid,
    input logic               scan_stall,
    input logic               key_pressed,
    input logic [ROW_W-1:0]   key_row,
    input logic [COL_W-1:0]   key_col,
    input logic [PCT_W-1:0]   current_percent,
    input logic               result_valid,
    input logic               result_stall,
    input logic [1:0]         screen_mode,
    input logic [ENTRY_W-1:0] entry_value,
    input logic [LEN_W-1:0]   entry_length,
    input logic               set_strobe,
    input logic [PCT_W-1:0]   set_percent
);

    // a stalled result beat holds
    `KPSM_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && result_stall, result_valid && $stable(screen_mode) && $stable(entry_value) && $stable(set_strobe))

    // scan side stalls only behind a stalled result
    `KPSM_ASSERT_NOW(a_stall_cause, clk, rst_n, scan_stall, result_valid && result_stall)

    // commit returns to the menu with the entry value in range
    `KPSM_ASSERT_NOW(a_commit_menu, clk, rst_n, result_valid && set_strobe, screen_mode == MODE_MENU && set_percent <= PCT_W'(TOP_PERCENT) && set_percent == entry_value[PCT_W-1:0] && entry_value[ENTRY_W-1:PCT_W] == '0)

    // no strobe, no setpoint
    `KPSM_ASSERT_NOW(a_idle_setpoint, clk, rst_n, result_valid && !set_strobe, set_percent == '0)

endmodule

bind keypad_setpoint_menu kpsm_checker u_kpsm_checker (.*);
